// File: hw/rtl/lcdnw_pkg.sv
package lcdnw_pkg;

  // request codes
  localparam logic [2:0] ACT_DATA   = 3'd0;
  localparam logic [2:0] ACT_CMD    = 3'd1;
  localparam logic [2:0] ACT_GOTO   = 3'd2;
  localparam logic [2:0] ACT_NUMBER = 3'd3;
  localparam logic [2:0] ACT_INIT   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_TWO_LINES  = 3'd0;
  localparam logic [2:0] CFG_LARGE_FONT = 3'd1;
  localparam logic [2:0] CFG_DISPLAY_ON = 3'd2;
  localparam logic [2:0] CFG_CURSOR_ON  = 3'd3;
  localparam logic [2:0] CFG_BLINK_ON   = 3'd4;

  // lcd command and character constants
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DDRAM_ROW0 = 8'h80;
  localparam logic [7:0] CMD_DDRAM_ROW1 = 8'hC0;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;

  // byte buffer sizing
  localparam int         MAX_BYTES = 5;
  localparam int         IDX_W     = 3;
  localparam logic [IDX_W-1:0] LAST_DIGIT_IDX = IDX_W'(MAX_BYTES - 1);

  // reciprocal of ten, exact for every 16-bit dividend with a shift of 19
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic two_lines;
    logic large_font;
    logic display_on;
    logic cursor_on;
    logic blink_on;
  } cfg_t;

endpackage

// File: hw/rtl/lcdnw_ifs.sv
interface lcdnw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  byte_value;
  logic [1:0]  row;
  logic [5:0]  column;
  logic [15:0] number;

  modport source (output valid, action, byte_value, row, column, number, input ready);
  modport sink   (input valid, action, byte_value, row, column, number, output ready);
endinterface

interface lcdnw_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, reg_select, nibble, last, input ready);
  modport sink   (input valid, reg_select, nibble, last, output ready);
endinterface

// File: hw/rtl/char_lcd_nibble_writer.sv
// start: a data, command or go-to request is written into the byte buffer as the sequencer enters
// emit, and its first nibble enters the output register once that is empty or being taken;
// a number request first converts its digits (1 to 5) one at a time in the divide-by-ten unit
// requests: one at a time, ready again after its final nibble enters the output register
// reset: synchronous active-low rst_n clears the sequencer and the output valid, and loads
// the config flags with two_lines=1, large_font=0, display_on=1, cursor_on=0, blink_on=0
module char_lcd_nibble_writer (
  input  logic       clk,
  input  logic       rst_n,
  lcdnw_in_if.sink   in_req,
  lcdnw_out_if.source out_nib,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic       cfg_wdata
);
  import lcdnw_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TWO_LINES:  cfg_nxt.two_lines  = cfg_wdata;
        CFG_LARGE_FONT: cfg_nxt.large_font = cfg_wdata;
        CFG_DISPLAY_ON: cfg_nxt.display_on = cfg_wdata;
        CFG_CURSOR_ON:  cfg_nxt.cursor_on  = cfg_wdata;
        CFG_BLINK_ON:   cfg_nxt.blink_on   = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{two_lines: 1'b1, large_font: 1'b0, display_on: 1'b1,
                 cursor_on: 1'b0, blink_on: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // request sequencer
  lcdnw_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_req  (in_req),
    .out_nib (out_nib)
  );

endmodule

// File: hw/rtl/lcdnw_div10.sv
module lcdnw_div10 (
  input  logic [15:0] dividend,
  output logic [15:0] quotient,
  output logic [3:0]  remainder
);
  import lcdnw_pkg::*;

  logic [31:0] prod;
  logic [15:0] quo_x10;

  // quotient by reciprocal multiply
  assign prod     = dividend * RECIP_TEN;
  assign quotient = 16'(prod[31:RECIP_SHIFT]);

  // remainder from quotient times ten, built from shifts
  assign quo_x10   = 16'({quotient, 3'b000}) + 16'({quotient, 1'b0});
  assign remainder = 4'(dividend - quo_x10);

endmodule

// File: hw/rtl/lcdnw_seq.sv
module lcdnw_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  lcdnw_pkg::cfg_t    cfg,
  lcdnw_in_if.sink           in_req,
  lcdnw_out_if.source        out_nib
);
  import lcdnw_pkg::*;

  state_t           state_r, state_nxt;
  logic [15:0]      val_r, val_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             half_r, half_nxt;
  logic             rs_r, rs_nxt;
  logic [7:0]       byte_r [MAX_BYTES];
  logic [7:0]       byte_nxt [MAX_BYTES];

  logic             out_valid_r, out_valid_nxt;
  logic             out_rs_r, out_rs_nxt;
  logic [3:0]       out_nib_r, out_nib_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             load;
  logic             conv_done;
  logic [15:0]      quo;
  logic [3:0]       rem;
  logic [7:0]       cur_byte;

  // divide-by-ten unit for digit conversion
  lcdnw_div10 u_div10 (
    .dividend  (val_r),
    .quotient  (quo),
    .remainder (rem)
  );

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign load         = (state_r == ST_EMIT) && (!out_valid_r || out_nib.ready);
  assign conv_done    = (quo == 16'd0) || (cnt_r == LAST_DIGIT_IDX);
  assign cur_byte     = byte_r[idx_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.action)
            ACT_DATA, ACT_CMD, ACT_INIT: state_nxt = ST_EMIT;
            ACT_GOTO: begin
              if (in_req.row == 2'd0 || in_req.row == 2'd1) begin
                state_nxt = ST_EMIT;
              end
            end
            ACT_NUMBER: state_nxt = ST_CONV;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load && half_r && idx_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // byte buffer, digit conversion and emission pointers
  always_comb begin
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    half_nxt = half_r;
    rs_nxt   = rs_r;
    byte_nxt = byte_r;
    case (state_r)
      ST_IDLE: begin
        half_nxt = 1'b0;
        idx_nxt  = '0;
        cnt_nxt  = IDX_W'(1);
        case (in_req.action)
          ACT_DATA: begin
            byte_nxt[0] = in_req.byte_value;
            rs_nxt      = 1'b1;
          end
          ACT_CMD: begin
            byte_nxt[0] = in_req.byte_value;
            rs_nxt      = 1'b0;
          end
          ACT_GOTO: begin
            byte_nxt[0] = (in_req.row[0] ? CMD_DDRAM_ROW1 : CMD_DDRAM_ROW0)
                          | {2'b00, in_req.column};
            rs_nxt      = 1'b0;
          end
          ACT_NUMBER: begin
            val_nxt = in_req.number;
            cnt_nxt = '0;
            rs_nxt  = 1'b1;
          end
          ACT_INIT: begin
            // buffer drains from the top index down
            byte_nxt[3] = {4'b0010, cfg.two_lines, cfg.large_font, 2'b00};
            byte_nxt[2] = {5'b00001, cfg.display_on, cfg.cursor_on, cfg.blink_on};
            byte_nxt[1] = CMD_CLEAR;
            byte_nxt[0] = CMD_ENTRY_MODE;
            cnt_nxt     = IDX_W'(4);
            idx_nxt     = IDX_W'(3);
            rs_nxt      = 1'b0;
          end
          default: begin
            rs_nxt = rs_r;
          end
        endcase
      end
      ST_CONV: begin
        // least significant digit first, so the top index holds the leading digit
        byte_nxt[cnt_r] = ASCII_ZERO | {4'b0000, rem};
        val_nxt         = quo;
        cnt_nxt         = cnt_r + IDX_W'(1);
        idx_nxt         = cnt_r;
      end
      ST_EMIT: begin
        if (load) begin
          if (half_r) begin
            half_nxt = 1'b0;
            idx_nxt  = idx_r - IDX_W'(1);
          end else begin
            half_nxt = 1'b1;
          end
        end
      end
      default: begin
        half_nxt = 1'b0;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rs_nxt    = out_rs_r;
    out_nib_nxt   = out_nib_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_nib.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_rs_nxt    = rs_r;
      out_nib_nxt   = half_r ? cur_byte[3:0] : cur_byte[7:4];
      out_last_nxt  = half_r && (idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    rs_r       <= rs_nxt;
    byte_r     <= byte_nxt;
    out_rs_r   <= out_rs_nxt;
    out_nib_r  <= out_nib_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_nib.valid      = out_valid_r;
  assign out_nib.reg_select = out_rs_r;
  assign out_nib.nibble     = out_nib_r;
  assign out_nib.last       = out_last_r;

  // emission pointer stays inside the filled part of the buffer
  a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> (cnt_r != '0) && (idx_r < cnt_r))
    else $error("emission index outside byte buffer");

  // conversion never runs past five digits
  a_conv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |-> cnt_r < IDX_W'(MAX_BYTES))
    else $error("digit count overflow");

  // loading the final nibble ends the request
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && half_r && idx_r == '0) |=> (state_r == ST_IDLE) && out_last_r)
    else $error("final nibble did not return to idle");

  // a conversion always moves on to emission with at least one digit
  a_conv_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && conv_done) |=> state_r == ST_EMIT && !half_r)
    else $error("conversion did not start emission");

endmodule
